[rtl/hpt_pkg.sv]
`timescale 1ns / 1ps

package hpt_pkg;

   // Field and port geometry fixed by the stream format.
   localparam int FIELD_WIDTH       = 32;
   localparam int NUM_IN_FIELDS     = 3;
   localparam int NUM_OUT_FIELDS    = 4;
   localparam int REQ_TDATA_WIDTH   = FIELD_WIDTH * NUM_IN_FIELDS;
   localparam int RSP_TDATA_WIDTH   = FIELD_WIDTH * NUM_OUT_FIELDS;

   // Coefficient register file: eight 64-bit words, two coefficients each.
   localparam int NUM_ROWS          = 4;
   localparam int NUM_COLS          = 4;
   localparam int NUM_COEF          = NUM_ROWS * NUM_COLS;
   localparam int NUM_CSR_WORDS     = NUM_COEF / 2;
   localparam int CSR_INDEX_WIDTH   = 4;
   localparam int CSR_DATA_WIDTH    = 64;

   // Default number format.
   localparam int DEFAULT_FRAC_BITS  = 16;
   localparam int DEFAULT_DATA_WIDTH = 32;

   // The diagonal of the reset matrix holds this 32-bit word.
   localparam logic [FIELD_WIDTH-1:0] COEF_ONE_WORD = 32'h0001_0000;

   // Pipeline depth: multiply, partial sums, final sum, round and clamp.
   localparam int NUM_STAGES = 4;

   // Reset word of coefficient idx (row-major): identity matrix.
   function automatic logic [FIELD_WIDTH-1:0] coef_reset_word(input int idx);
      logic [FIELD_WIDTH-1:0] word;
      word = '0;
      if ((idx / NUM_COLS) == (idx % NUM_COLS)) begin
         word = COEF_ONE_WORD;
      end
      return word;
   endfunction

endpackage

[rtl/homogeneous_point_transform_top.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// req_      in         req_tvalid/req_tready   req_tdata: point_x, point_y, point_z
// rsp_      out        rsp_tvalid/rsp_tready   rsp_tdata: out_x, out_y, out_z, out_w
// csr_      in         csr_valid/csr_ready     csr_index, csr_data (64-bit coefficient pair)
//
// One point enters per cycle while the pipeline is not stalled.
// The depth is set by four register stages: the twelve multipliers, two
// partial sums per row, the final row sum, and the rounding and clamping.
// Reset is synchronous and restores the identity matrix and an empty pipeline.
// A stall on rsp_ backs up only as far as the first empty stage; no beat is
// dropped or repeated. csr_ready is always high.

module homogeneous_point_transform_top
   import hpt_pkg::*;
#(
   parameter int FRAC_BITS  = DEFAULT_FRAC_BITS,
   parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   // Point beats: point_x [31:0], point_y [63:32], point_z [95:64].
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // Result beats: out_x [31:0], out_y [63:32], out_z [95:64], out_w [127:96].
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // Coefficient writes.
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   // Product width, and a row-sum width that also holds the scaled
   // translation term and the rounding constant without overflow.
   localparam int PW  = 2 * DATA_WIDTH;
   localparam int TW  = DATA_WIDTH - 1 + FRAC_BITS;
   localparam int SW  = ((PW > TW) ? PW : TW) + 2;
   localparam int QW  = SW - FRAC_BITS;
   localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);

   // Coefficient store.
   logic signed [DATA_WIDTH-1:0] coef_ff [NUM_COEF];

   // Pipeline registers.
   logic [NUM_STAGES-1:0]        valid_ff;
   logic [NUM_STAGES-1:0]        advance;
   logic signed [PW-1:0]         prod_ff   [NUM_ROWS][3];
   logic signed [SW-1:0]         part_a_ff [NUM_ROWS];
   logic signed [SW-1:0]         part_b_ff [NUM_ROWS];
   logic signed [SW-1:0]         sum_ff    [NUM_ROWS];
   logic signed [DATA_WIDTH-1:0] out_ff    [NUM_ROWS];

   logic signed [DATA_WIDTH-1:0] point [3];

   // Coefficient writes; an index past the last word is ignored.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF; i++) begin
            coef_ff[i] <= DATA_WIDTH'(coef_reset_word(i));
         end
      end else if (csr_valid && csr_ready
                   && (csr_index < CSR_INDEX_WIDTH'(NUM_CSR_WORDS))) begin
         for (int w = 0; w < NUM_CSR_WORDS; w++) begin
            if (csr_index == CSR_INDEX_WIDTH'(w)) begin
               coef_ff[2*w]   <= csr_data[DATA_WIDTH-1:0];
               coef_ff[2*w+1] <= csr_data[FIELD_WIDTH +: DATA_WIDTH];
            end
         end
      end
   end

   // Flow control: a stage moves when it is empty or the next one moves.
   always_comb begin
      advance[NUM_STAGES-1] = rsp_tready || !valid_ff[NUM_STAGES-1];
      for (int s = NUM_STAGES - 2; s >= 0; s--) begin
         advance[s] = advance[s+1] || !valid_ff[s];
      end
   end

   assign req_tready = advance[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (advance[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int s = 1; s < NUM_STAGES; s++) begin
            if (advance[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   // Only the low DATA_WIDTH bits of each coordinate count.
   always_comb begin
      for (int f = 0; f < 3; f++) begin
         point[f] = req_tdata[f*FIELD_WIDTH +: DATA_WIDTH];
      end
   end

   // Stage 1: twelve independent signed multiplies.
   always_ff @(posedge clock) begin
      if (advance[0]) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= PW'(coef_ff[r*NUM_COLS + c]) * PW'(point[c]);
            end
         end
      end
   end

   // Stage 2: two partial sums per row; the translation term is scaled to
   // the product format and carries the rounding constant.
   always_ff @(posedge clock) begin
      if (advance[1]) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            part_a_ff[r] <= SW'(prod_ff[r][0]) + SW'(prod_ff[r][1]);
            part_b_ff[r] <= SW'(prod_ff[r][2])
                            + (SW'(coef_ff[r*NUM_COLS + 3]) <<< FRAC_BITS) + HALF;
         end
      end
   end

   // Stage 3: full row sum.
   always_ff @(posedge clock) begin
      if (advance[2]) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            sum_ff[r] <= part_a_ff[r] + part_b_ff[r];
         end
      end
   end

   // Stage 4: drop the fraction (round half up was folded in) and clamp.
   always_ff @(posedge clock) begin
      logic signed [QW-1:0] q;
      logic                 pos_ovf;
      logic                 neg_ovf;
      if (advance[3]) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            q       = sum_ff[r][SW-1:FRAC_BITS];
            pos_ovf = !q[QW-1] && (|q[QW-2:DATA_WIDTH-1]);
            neg_ovf = q[QW-1] && !(&q[QW-2:DATA_WIDTH-1]);
            if (pos_ovf) begin
               out_ff[r] <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
            end else if (neg_ovf) begin
               out_ff[r] <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
            end else begin
               out_ff[r] <= q[DATA_WIDTH-1:0];
            end
         end
      end
   end

   // Results, sign-extended to the 32-bit fields.
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];

   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         rsp_tdata[r*FIELD_WIDTH +: FIELD_WIDTH] = FIELD_WIDTH'(out_ff[r]);
      end
   end

   // A gap anywhere in the pipeline lets a new point in.
   a_ready_on_gap: assert property (@(posedge clock) disable iff (reset)
      (valid_ff != {NUM_STAGES{1'b1}}) |-> req_tready)
      else $error("input stalled although the pipeline has an empty stage");

   // A full pipeline with a stalled output takes no new point.
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      ((valid_ff == {NUM_STAGES{1'b1}}) && !rsp_tready) |-> !req_tready)
      else $error("input accepted while the full pipeline is stalled");

   // A stalled last stage keeps the stage behind it occupied.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NUM_STAGES-1] && valid_ff[NUM_STAGES-2] && !rsp_tready)
      |=> valid_ff[NUM_STAGES-2])
      else $error("beat lost behind a stalled output");

endmodule

[tb/tb_homogeneous_point_transform_top.sv]
`timescale 1ns / 1ps

module tb_homogeneous_point_transform_top;
   import hpt_pkg::*;

   localparam int FRAC       = DEFAULT_FRAC_BITS;
   localparam int ACC_WIDTH  = 2 * FIELD_WIDTH + 4;
   localparam int CLK_HALF   = 5;
   localparam int RESET_CYCLES = 8;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int TIMEOUT_NS = 3_000_000;

   localparam logic signed [FIELD_WIDTH-1:0] Q_MAX  = 32'sh7fff_ffff;
   localparam logic signed [FIELD_WIDTH-1:0] Q_MIN  = 32'sh8000_0000;
   localparam logic signed [FIELD_WIDTH-1:0] Q_ONE  = 32'sh0001_0000;
   localparam logic signed [FIELD_WIDTH-1:0] Q_HALF = 32'sh0000_8000;

   localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF = ACC_WIDTH'(1) <<< (FRAC - 1);
   localparam logic signed [ACC_WIDTH-1:0] SAT_HIGH   = ACC_WIDTH'(Q_MAX);
   localparam logic signed [ACC_WIDTH-1:0] SAT_LOW    = -SAT_HIGH - 1;

   // Register map of the coefficient file, one word per half row.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      ROW0_FIRST_PAIR,
      ROW0_SECOND_PAIR,
      ROW1_FIRST_PAIR,
      ROW1_SECOND_PAIR,
      ROW2_FIRST_PAIR,
      ROW2_SECOND_PAIR,
      ROW3_FIRST_PAIR,
      ROW3_SECOND_PAIR
   } coef_reg_e;

   // Packed so that x lands in the lowest bits of the beat.
   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] z;
      logic signed [FIELD_WIDTH-1:0] y;
      logic signed [FIELD_WIDTH-1:0] x;
   } point_t;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] w;
      logic signed [FIELD_WIDTH-1:0] z;
      logic signed [FIELD_WIDTH-1:0] y;
      logic signed [FIELD_WIDTH-1:0] x;
   } vertex_t;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   // Shadow of the coefficient words and the matrix staged for loading.
   logic [CSR_DATA_WIDTH-1:0]     coef_words [NUM_CSR_WORDS];
   logic signed [FIELD_WIDTH-1:0] staged [NUM_COEF];

   vertex_t transformed_q [$];

   bit sender_gaps_on    = 1'b1;
   bit receiver_stalls_on = 1'b1;
   int rsp_hold_cycles   = 0;
   int stall_left        = 0;
   int error_count       = 0;
   int points_sent       = 0;
   int vertices_checked  = 0;
   int coef_writes       = 0;

   homogeneous_point_transform_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Sign-extend a coordinate or coefficient to the accumulator width.
   function automatic logic signed [ACC_WIDTH-1:0] widen(input logic signed [FIELD_WIDTH-1:0] v);
      widen = v;
   endfunction

   // One row of the matrix applied to (x, y, z, 1): exact sum, round half up, clamp.
   function automatic logic signed [FIELD_WIDTH-1:0] row_dot(input int row, input point_t pt);
      logic [CSR_DATA_WIDTH-1:0]     first_pair;
      logic [CSR_DATA_WIDTH-1:0]     second_pair;
      logic signed [FIELD_WIDTH-1:0] c0, c1, c2, c3;
      logic signed [ACC_WIDTH-1:0]   acc;
      first_pair  = coef_words[2 * row];
      second_pair = coef_words[2 * row + 1];
      c0 = first_pair[31:0];
      c1 = first_pair[63:32];
      c2 = second_pair[31:0];
      c3 = second_pair[63:32];
      acc = (widen(c3) <<< FRAC) + widen(c0) * widen(pt.x) + widen(c1) * widen(pt.y)
            + widen(c2) * widen(pt.z);
      acc = (acc + ROUND_HALF) >>> FRAC;
      if (acc > SAT_HIGH) begin
         return Q_MAX;
      end else if (acc < SAT_LOW) begin
         return Q_MIN;
      end
      return acc[FIELD_WIDTH-1:0];
   endfunction

   function automatic vertex_t transform_point(input point_t pt);
      vertex_t v;
      v.x = row_dot(0, pt);
      v.y = row_dot(1, pt);
      v.z = row_dot(2, pt);
      v.w = row_dot(3, pt);
      return v;
   endfunction

   function automatic void compare_field(input string name,
                                         input logic signed [FIELD_WIDTH-1:0] want,
                                         input logic signed [FIELD_WIDTH-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Watch both channels: predict each accepted point, check each result beat,
   // and mirror every accepted coefficient write.
   always @(posedge clock) begin
      vertex_t want;
      vertex_t got;
      if (reset) begin
         for (int k = 0; k < NUM_CSR_WORDS; k++) begin
            coef_words[k] = {coef_reset_word(2 * k + 1), coef_reset_word(2 * k)};
         end
      end else begin
         if (req_tvalid && req_tready) begin
            transformed_q.push_back(transform_point(point_t'(req_tdata)));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = vertex_t'(rsp_tdata);
            if (transformed_q.size() == 0) begin
               $error("result beat with no point outstanding: %h", rsp_tdata);
               error_count++;
            end else begin
               want = transformed_q.pop_front();
               compare_field("out_x", want.x, got.x);
               compare_field("out_y", want.y, got.y);
               compare_field("out_z", want.z, got.z);
               compare_field("out_w", want.w, got.w);
               vertices_checked++;
            end
         end
         if (csr_valid && csr_ready && csr_index < NUM_CSR_WORDS) begin
            coef_words[csr_index] = csr_data;
         end
      end
   end

   // Result side: an optional long hold-off, then random stall bursts.
   always begin
      @(negedge clock);
      if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles--;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (receiver_stalls_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offer one point, with an occasional gap before it, and wait for acceptance.
   task automatic send_point(input point_t pt);
      int gap;
      gap = (sender_gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pt;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      points_sent++;
   endtask

   task automatic send_xyz(input logic signed [FIELD_WIDTH-1:0] x, y, z);
      point_t pt;
      pt.x = x;
      pt.y = y;
      pt.z = z;
      send_point(pt);
   endtask

   // Stop offering points and wait until every result has come back.
   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (transformed_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      coef_writes++;
   endtask

   // Drain the pipeline, then write the staged matrix as eight pair words.
   task automatic load_matrix;
      coef_reg_e idx;
      drain();
      for (int k = 0; k < NUM_CSR_WORDS; k++) begin
         idx = coef_reg_e'(k);
         write_register(idx, {staged[2 * k + 1], staged[2 * k]});
      end
   endtask

   function automatic void stage_fill(input logic signed [FIELD_WIDTH-1:0] value);
      for (int k = 0; k < NUM_COEF; k++) staged[k] = value;
   endfunction

   function automatic logic signed [FIELD_WIDTH-1:0] random_coef(input bit wide);
      case ($urandom_range(0, 9))
         0: return wide ? $urandom : Q_ONE;
         1: return '0;
         2: return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
         default: return int'($urandom_range(0, 524287)) - 262144;
      endcase
   endfunction

   function automatic logic signed [FIELD_WIDTH-1:0] random_coord;
      case ($urandom_range(0, 7))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(0, 4))
               0: return Q_MAX;
               1: return Q_MIN;
               2: return '0;
               3: return -1;
               default: return 1;
            endcase
         end
         default: return int'($urandom_range(0, 33554431)) - 16777216;
      endcase
   endfunction

   task automatic stage_random_matrix(input bit wide);
      for (int k = 0; k < NUM_COEF; k++) staged[k] = random_coef(wide);
      load_matrix();
   endtask

   task automatic send_random_points(input int count);
      repeat (count) send_xyz(random_coord(), random_coord(), random_coord());
   endtask

   // The reset matrix passes points through, extremes included.
   task automatic test_reset_identity;
      send_xyz('0, '0, '0);
      send_xyz(Q_MAX, Q_MIN, -1);
      send_xyz(Q_MIN, Q_MAX, 1);
      send_xyz(Q_ONE, -Q_ONE, 32'sh7fff_8000);
   endtask

   // Half-ulp products land on ties, which round toward plus infinity.
   task automatic test_rounding_ties;
      stage_fill('0);
      staged[0]  = Q_HALF;
      staged[5]  = -Q_HALF;
      staged[10] = Q_HALF;
      staged[11] = 1;
      staged[15] = Q_ONE;
      load_matrix();
      send_xyz(1, 1, 1);
      send_xyz(-1, -1, -1);
      send_xyz(3, 3, 3);
      send_xyz(Q_ONE + 1, -Q_ONE - 3, 5);
   endtask

   // The largest and smallest coefficients drive every row into clamping.
   task automatic test_saturation;
      stage_fill(Q_MAX);
      load_matrix();
      send_xyz(Q_MAX, Q_MAX, Q_MAX);
      send_xyz(Q_MIN, Q_MIN, Q_MIN);
      stage_fill(Q_MIN);
      load_matrix();
      send_xyz(Q_MIN, Q_MIN, Q_MIN);
      send_xyz(Q_MAX, Q_MAX, Q_MAX);
      send_xyz('0, '0, '0);
   endtask

   // Writes to indexes past the last pair word must leave the matrix alone.
   task automatic test_ignored_index;
      stage_random_matrix(1'b0);
      for (int k = NUM_CSR_WORDS; k < (1 << CSR_INDEX_WIDTH); k++) begin
         write_register(CSR_INDEX_WIDTH'(k), {$urandom, $urandom});
      end
      send_xyz(Q_ONE, Q_ONE, Q_ONE);
      send_random_points(1);
   endtask

   // Hold the result side off while points keep coming, so the input stalls.
   task automatic test_backpressure;
      stage_random_matrix(1'b0);
      sender_gaps_on = 1'b0;
      @(negedge clock);
      rsp_hold_cycles = HOLD_OFF_CYCLES;
      send_random_points(40);
      sender_gaps_on = 1'b1;
   endtask

   task automatic test_random_matrices;
      for (int phase = 0; phase < 9; phase++) begin
         stage_random_matrix(phase % 3 == 2);
         send_random_points(120);
      end
   endtask

   // Closing stretch with both sides at full rate.
   task automatic test_full_rate_stream;
      stage_random_matrix(1'b1);
      sender_gaps_on     = 1'b0;
      receiver_stalls_on = 1'b0;
      send_random_points(130);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_identity();
      test_rounding_ties();
      test_saturation();
      test_ignored_index();
      test_backpressure();
      test_random_matrices();
      test_full_rate_stream();

      drain();
      repeat (4 * NUM_STAGES) @(posedge clock);

      $display("Sent %0d points and checked %0d vertices over %0d coefficient writes.",
               points_sent, vertices_checked, coef_writes);
      $display("Matrices: identity, rounding ties, both clamp ends, ignored indexes, random.");
      if (error_count == 0) begin
         $display("tb_homogeneous_point_transform_top passed");
      end else begin
         $display("tb_homogeneous_point_transform_top failed");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("Timed out with %0d vertices outstanding.", transformed_q.size());
      $display("tb_homogeneous_point_transform_top failed");
      $finish;
   end

endmodule
